[rtl/core/hsfd_pkg.sv]
// Package: shared types, constants and the CRC-8 byte step for the frame decoder.
package hsfd_pkg;

   localparam int unsigned FRAME_LEN   = 6;
   localparam int unsigned COUNT_W     = 3;
   localparam logic [7:0]  CRC_INIT    = 8'hFF;
   localparam logic [7:0]  CRC_POLY    = 8'h31;

   // Byte positions within a frame
   localparam logic [COUNT_W-1:0] POS_T_HI  = 3'd0;
   localparam logic [COUNT_W-1:0] POS_T_LO  = 3'd1;
   localparam logic [COUNT_W-1:0] POS_T_CRC = 3'd2;
   localparam logic [COUNT_W-1:0] POS_H_HI  = 3'd3;
   localparam logic [COUNT_W-1:0] POS_H_LO  = 3'd4;
   localparam logic [COUNT_W-1:0] POS_H_CRC = 3'd5;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;
   localparam logic [COUNT_W-1:0] COUNT_OK  = 3'd6;

   // Conversion constants: temp = -4500 + 17500*raw/65535, hum = 10000*raw/65535
   localparam int unsigned TEMP_SPAN   = 17500;
   localparam int unsigned HUM_SPAN    = 10000;
   localparam int unsigned TEMP_OFFSET = 4500;
   localparam int unsigned TEMP_MAX    = 13000;
   localparam int unsigned PROD_T_W    = 31;
   localparam int unsigned PROD_H_W    = 30;
   localparam int unsigned TEMP_W      = 15;
   localparam int unsigned HUM_W       = 14;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_COUNT = 2'd1,
      STATUS_BAD_TCRC  = 2'd2,
      STATUS_BAD_HCRC  = 2'd3
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] raw_t;
      logic [15:0] raw_h;
   } frame_res_type;

   function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[rtl/core/hsfd_frame.sv]
// Frame tracker: byte count, running CRC, stored data bytes and the per-frame result register.
module hsfd_frame (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             rx_byte,
   input  logic                   rx_last,
   output logic                   res_valid,
   input  logic                   res_ready,
   output hsfd_pkg::frame_res_type res
);
   import hsfd_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         crc_ff, crc_in;
   logic               tbad_ff, tbad_in;
   logic               hbad_ff, hbad_in;
   logic [7:0]         t_hi_ff, t_hi_in, t_lo_ff, t_lo_in;
   logic [7:0]         h_hi_ff, h_hi_in, h_lo_ff, h_lo_in;
   logic               res_valid_ff, res_valid_in;
   frame_res_type      res_ff, res_in;
   logic               accept;

   assign req_ready = !res_valid_ff || res_ready;
   assign accept    = req_valid && req_ready;
   assign res_valid = res_valid_ff;
   assign res       = res_ff;

   always_comb begin
      status_type st;
      count_in     = count_ff;
      crc_in       = crc_ff;
      tbad_in      = tbad_ff;
      hbad_in      = hbad_ff;
      t_hi_in      = t_hi_ff;
      t_lo_in      = t_lo_ff;
      h_hi_in      = h_hi_ff;
      h_lo_in      = h_lo_ff;
      res_in       = res_ff;
      res_valid_in = res_valid_ff && !res_ready;
      st           = STATUS_OK;
      if (accept) begin
         case (count_ff)
            POS_T_HI: begin
               t_hi_in = rx_byte;
               crc_in  = crc_fold(crc_ff, rx_byte);
            end
            POS_T_LO: begin
               t_lo_in = rx_byte;
               crc_in  = crc_fold(crc_ff, rx_byte);
            end
            POS_T_CRC: begin
               tbad_in = (rx_byte != crc_ff);
               crc_in  = CRC_INIT;
            end
            POS_H_HI: begin
               h_hi_in = rx_byte;
               crc_in  = crc_fold(crc_ff, rx_byte);
            end
            POS_H_LO: begin
               h_lo_in = rx_byte;
               crc_in  = crc_fold(crc_ff, rx_byte);
            end
            POS_H_CRC: begin
               hbad_in = (rx_byte != crc_ff);
            end
            default: begin
               // bytes past the sixth are dropped
            end
         endcase
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + 1'b1;
         end
         if (rx_last) begin
            if (count_in != COUNT_OK) begin
               st = STATUS_BAD_COUNT;
            end else if (tbad_in) begin
               st = STATUS_BAD_TCRC;
            end else if (hbad_in) begin
               st = STATUS_BAD_HCRC;
            end
            res_in.status = st;
            res_in.raw_t  = {t_hi_in, t_lo_in};
            res_in.raw_h  = {h_hi_in, h_lo_in};
            res_valid_in  = 1'b1;
            // start a fresh frame
            count_in = '0;
            crc_in   = CRC_INIT;
            tbad_in  = 1'b0;
            hbad_in  = 1'b0;
            t_hi_in  = '0;
            t_lo_in  = '0;
            h_hi_in  = '0;
            h_lo_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         crc_ff       <= CRC_INIT;
         tbad_ff      <= 1'b0;
         hbad_ff      <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         tbad_ff      <= tbad_in;
         hbad_ff      <= hbad_in;
         res_valid_ff <= res_valid_in;
      end
      t_hi_ff <= t_hi_in;
      t_lo_ff <= t_lo_in;
      h_hi_ff <= h_hi_in;
      h_lo_ff <= h_lo_in;
      res_ff  <= res_in;
   end

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && rx_last |=> count_ff == '0 && crc_ff == CRC_INIT && !tbad_ff && !hbad_ff)
      else $error("frame state not restarted after last byte");

   a_crc_reload: assert property (@(posedge clock) disable iff (reset)
      accept && !rx_last && count_ff == POS_T_CRC |=> crc_ff == CRC_INIT)
      else $error("running crc not reloaded after temperature crc byte");

   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      accept && !rx_last && count_ff == COUNT_MAX |=> count_ff == COUNT_MAX)
      else $error("byte count left saturation");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && !res_ready |=> res_valid_ff && $stable(res_ff))
      else $error("frame result lost while stalled");

endmodule

[rtl/core/hsfd_convert.sv]
// Conversion pipeline: scale raw words by a multiply stage, then divide by 65535 and offset.
module hsfd_convert (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    res_valid,
   output logic                    res_ready,
   input  hsfd_pkg::frame_res_type res,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [14:0]      rsp_temperature_centi,
   output logic [13:0]             rsp_humidity_centi,
   output logic [15:0]             rsp_raw_temperature,
   output logic [15:0]             rsp_raw_humidity
);
   import hsfd_pkg::*;

   // product stage
   logic                  prod_valid_ff;
   frame_res_type         prod_res_ff;
   logic [PROD_T_W-1:0]   prod_t_ff, prod_t_in;
   logic [PROD_H_W-1:0]   prod_h_ff, prod_h_in;
   logic                  prod_ready;

   // output stage
   logic                  out_valid_ff;
   frame_res_type         out_res_ff;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic [HUM_W-1:0]      hum_ff, hum_in;
   logic                  out_ready;

   logic [PROD_T_W:0]     sum_t;
   logic [PROD_H_W:0]     sum_h;
   logic [TEMP_W-1:0]     q_t;

   assign out_ready  = !out_valid_ff || rsp_ready;
   assign prod_ready = !prod_valid_ff || out_ready;
   assign res_ready  = prod_ready;

   assign prod_t_in = PROD_T_W'(res.raw_t) * PROD_T_W'(TEMP_SPAN);
   assign prod_h_in = PROD_H_W'(res.raw_h) * PROD_H_W'(HUM_SPAN);

   // floor(p / 65535) = (p + (p >> 16) + 1) >> 16 while p / 65535 stays below 65536
   assign sum_t = (PROD_T_W + 1)'(prod_t_ff) + (PROD_T_W + 1)'(prod_t_ff >> 16)
                  + (PROD_T_W + 1)'(1);
   assign sum_h = (PROD_H_W + 1)'(prod_h_ff) + (PROD_H_W + 1)'(prod_h_ff >> 16)
                  + (PROD_H_W + 1)'(1);
   assign q_t   = sum_t[TEMP_W+15:16];

   always_comb begin
      temp_in = '0;
      hum_in  = '0;
      if (prod_res_ff.status == STATUS_OK) begin
         temp_in = $signed(q_t - TEMP_W'(TEMP_OFFSET));
         hum_in  = sum_h[HUM_W+15:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (prod_ready) begin
            prod_valid_ff <= res_valid;
         end
         if (out_ready) begin
            out_valid_ff <= prod_valid_ff;
         end
      end
      if (prod_ready && res_valid) begin
         prod_res_ff <= res;
         prod_t_ff   <= prod_t_in;
         prod_h_ff   <= prod_h_in;
      end
      if (out_ready && prod_valid_ff) begin
         out_res_ff <= prod_res_ff;
         temp_ff    <= temp_in;
         hum_ff     <= hum_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_status            = out_res_ff.status;
   assign rsp_temperature_centi = temp_ff;
   assign rsp_humidity_centi    = hum_ff;
   assign rsp_raw_temperature   = out_res_ff.raw_t;
   assign rsp_raw_humidity      = out_res_ff.raw_h;

   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.status != STATUS_OK |-> temp_ff == '0 && hum_ff == '0)
      else $error("converted values not zero on bad frame");

   a_range_ok: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.status == STATUS_OK |->
         hum_ff <= HUM_W'(HUM_SPAN) && temp_ff <= $signed(TEMP_W'(TEMP_MAX)))
      else $error("converted value out of range");

   a_prod_held: assert property (@(posedge clock) disable iff (reset)
      prod_valid_ff && !out_ready |=> prod_valid_ff && $stable(prod_t_ff) && $stable(prod_h_ff))
      else $error("product stage changed while stalled");

endmodule

[rtl/core/humidity_sensor_frame_decoder_core.sv]
// Top level: sensor read frame decoder with CRC-8 check and fixed-point conversion.
// Takes one received byte per cycle while req_ready is high (req_rx_last marks
// the final byte of a transfer) and gives one result per transfer: status, raw
// temperature and humidity words, and the converted values in hundredths. The
// result of a transfer passes a frame result register (loaded at the edge that
// accepts its last byte), a multiply register and an output register. Each of
// those three registers holds one result, so req_ready drops only when all
// three are full and rsp_ready is low.
module humidity_sensor_frame_decoder_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_rx_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [14:0] rsp_temperature_centi,
   output logic [13:0]        rsp_humidity_centi,
   output logic [15:0]        rsp_raw_temperature,
   output logic [15:0]        rsp_raw_humidity
);
   import hsfd_pkg::*;

   logic          frame_valid;
   logic          frame_ready;
   frame_res_type frame_res;

   hsfd_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rx_byte   (req_rx_byte),
      .rx_last   (req_rx_last),
      .res_valid (frame_valid),
      .res_ready (frame_ready),
      .res       (frame_res)
   );

   hsfd_convert u_convert (
      .clock                 (clock),
      .reset                 (reset),
      .res_valid             (frame_valid),
      .res_ready             (frame_ready),
      .res                   (frame_res),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_raw_temperature   (rsp_raw_temperature),
      .rsp_raw_humidity      (rsp_raw_humidity)
   );

endmodule

[tb/humidity_sensor_frame_decoder_core_tb.sv]
// Testbench for the sensor frame decoder: CRC-checked frames in, decoded readings checked out.
module humidity_sensor_frame_decoder_core_tb;
   import hsfd_pkg::*;

   localparam int unsigned FULL_SCALE  = 65535;
   localparam int          ITEM_TARGET = 500;
   localparam int          CALM_FROM   = 420;
   localparam int          HOLD_CYCLES = 80;
   localparam int          HOLD_FRAME  = 12;
   localparam int          DRAIN_FRAME = 30;
   localparam int          TAIL_CYCLES = 10;
   localparam int          CYCLE_LIMIT = 200000;

   typedef struct packed {
      status_type         status;
      logic signed [14:0] temp;
      logic [13:0]        hum;
      logic [15:0]        raw_t;
      logic [15:0]        raw_h;
   } reading_type;

   typedef struct {
      logic [7:0]  b;
      bit          last;
      bit          crc_slot;
      bit          typed;
      reading_type want;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_rx_byte;
   logic               req_rx_last;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_status;
   logic signed [14:0] rsp_temperature_centi;
   logic [13:0]        rsp_humidity_centi;
   logic [15:0]        rsp_raw_temperature;
   logic [15:0]        rsp_raw_humidity;

   // Predictor state
   logic [2:0] frame_pos;
   logic [7:0] frame_store [0:5];
   logic [7:0] crc_run;
   bit         tcrc_bad;
   bit         hcrc_bad;

   reading_type  pending_readings [$];
   stim_row_type directed_rows [$];
   int           mismatches = 0;
   int           cycles = 0;
   int           sender_gap_pct = 0;
   bit           calm = 1'b0;
   bit           hold_request = 1'b0;

   humidity_sensor_frame_decoder_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_rx_byte           (req_rx_byte),
      .req_rx_last           (req_rx_last),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_raw_temperature   (rsp_raw_temperature),
      .rsp_raw_humidity      (rsp_raw_humidity)
   );

   always #10 clock = ~clock;

   // CRC-8, poly 0x31, one data bit at a time, MSB first
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] d);
      logic [7:0] c;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         if (c[7] ^ d[i]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic void clear_frame();
      frame_pos = '0;
      for (int i = 0; i < FRAME_LEN; i++) begin
         frame_store[i] = '0;
      end
      crc_run  = CRC_INIT;
      tcrc_bad = 1'b0;
      hcrc_bad = 1'b0;
   endfunction

   // Advance the decoder by one byte; return 1 with the reading when the frame closes
   function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                      output reading_type r);
      logic [2:0]  pos;
      int unsigned tq;
      int unsigned hq;
      pos = frame_pos;
      r = '0;
      if (pos < FRAME_LEN) begin
         frame_store[pos] = b;
         if (pos == POS_T_CRC) begin
            tcrc_bad = (b != crc_run);
            crc_run  = CRC_INIT;
         end else if (pos == POS_H_CRC) begin
            hcrc_bad = (b != crc_run);
         end else begin
            crc_run = crc8_step(crc_run, b);
         end
      end
      if (frame_pos != COUNT_MAX) begin
         frame_pos = frame_pos + 3'd1;
      end
      if (!last) begin
         return 1'b0;
      end
      r.raw_t = {frame_store[POS_T_HI], frame_store[POS_T_LO]};
      r.raw_h = {frame_store[POS_H_HI], frame_store[POS_H_LO]};
      if (frame_pos != COUNT_OK) begin
         r.status = STATUS_BAD_COUNT;
      end else if (tcrc_bad) begin
         r.status = STATUS_BAD_TCRC;
      end else if (hcrc_bad) begin
         r.status = STATUS_BAD_HCRC;
      end else begin
         r.status = STATUS_OK;
      end
      if (r.status == STATUS_OK) begin
         tq = (TEMP_SPAN * r.raw_t) / FULL_SCALE;
         hq = (HUM_SPAN * r.raw_h) / FULL_SCALE;
         r.temp = 15'(tq - TEMP_OFFSET);
         r.hum  = 14'(hq);
      end
      clear_frame();
      return 1'b1;
   endfunction

   function automatic logic [15:0] pick_word();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
         return 16'h0000;
      end else if (roll == 1) begin
         return 16'hFFFF;
      end
      return 16'($urandom);
   endfunction

   function automatic void add_byte(input logic [7:0] b, input bit crc_slot);
      stim_row_type row;
      row.b        = b;
      row.last     = 1'b0;
      row.crc_slot = crc_slot;
      row.typed    = 1'b0;
      row.want     = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_typed(input logic [7:0] b, input status_type st, input int t,
                                     input int h, input logic [15:0] rt, input logic [15:0] rh);
      stim_row_type row;
      row.b           = b;
      row.last        = 1'b1;
      row.crc_slot    = 1'b0;
      row.typed       = 1'b1;
      row.want.status = st;
      row.want.temp   = 15'(t);
      row.want.hum    = 14'(h);
      row.want.raw_t  = rt;
      row.want.raw_h  = rh;
      directed_rows.push_back(row);
   endfunction

   // Offer one byte from a falling edge, after an optional random gap; return at the edge that accepts it
   task automatic offer_byte(input logic [7:0] b, input logic last);
      int gap;
      @(negedge clock);
      if (!calm && !hold_request && $urandom_range(0, 99) < sender_gap_pct) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      req_rx_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic check_field(input string what, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected reading, expected none, got status %0d raw %h/%h",
                     $time, rsp_status, rsp_raw_temperature, rsp_raw_humidity);
            mismatches++;
         end else begin
            want = pending_readings.pop_front();
            check_field("status", int'(want.status), int'(rsp_status));
            check_field("temperature_centi", int'($signed(want.temp)),
                        int'($signed(rsp_temperature_centi)));
            check_field("humidity_centi", int'(want.hum), int'(rsp_humidity_centi));
            check_field("raw_temperature", int'(want.raw_t), int'(rsp_raw_temperature));
            check_field("raw_humidity", int'(want.raw_h), int'(rsp_raw_humidity));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: random stalls, one long hold-off on request, none near the end
   initial begin : receiver
      int burst;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            rsp_ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 5);
            rsp_ready <= 1'b0;
            repeat (burst) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      reading_type  got;
      stim_row_type row;
      logic [7:0]   b;
      logic [15:0]  tw;
      logic [15:0]  hw;
      logic [7:0]   frame_buf [0:9];
      int           kind;
      int           len;
      int           frame_no;
      int           sent;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      req_rx_last = 1'b0;
      clear_frame();

      // zero words, both CRCs right
      add_byte(8'h00, 0); add_byte(8'h00, 0); add_byte(8'h81, 0);
      add_byte(8'h00, 0); add_byte(8'h00, 0);
      add_typed(8'h81, STATUS_OK, -4500, 0, 16'h0000, 16'h0000);
      // both CRCs wrong: temperature CRC takes precedence
      add_byte(8'h00, 0); add_byte(8'h00, 0); add_byte(8'h00, 0);
      add_byte(8'hFF, 0); add_byte(8'hFF, 0);
      add_typed(8'h00, STATUS_BAD_TCRC, 0, 0, 16'h0000, 16'hFFFF);
      // humidity CRC wrong only
      add_byte(8'hFF, 0); add_byte(8'hFF, 0); add_byte(8'h00, 1);
      add_byte(8'h00, 0); add_byte(8'h00, 0);
      add_typed(8'h00, STATUS_BAD_HCRC, 0, 0, 16'hFFFF, 16'h0000);
      // short frame, last mark on the humidity low byte
      add_byte(8'h12, 0); add_byte(8'h34, 0); add_byte(8'h00, 0); add_byte(8'h56, 0);
      add_typed(8'h78, STATUS_BAD_COUNT, 0, 0, 16'h1234, 16'h5678);
      // long frame with good CRCs; trailing byte ignored but count is wrong
      add_byte(8'h11, 0); add_byte(8'h22, 0); add_byte(8'h00, 1);
      add_byte(8'h33, 0); add_byte(8'h44, 0); add_byte(8'h00, 1);
      add_typed(8'h55, STATUS_BAD_COUNT, 0, 0, 16'h1122, 16'h3344);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sent = 0;
      sender_gap_pct = 20;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         b = row.crc_slot ? crc_run : row.b;
         offer_byte(b, row.last);
         if (decode_byte(b, row.last, got)) begin
            pending_readings.push_back(row.typed ? row.want : got);
         end
         sent++;
      end

      frame_no = 0;
      while (sent < ITEM_TARGET) begin
         frame_no++;
         case ($urandom_range(0, 2))
            0: sender_gap_pct = 0;
            1: sender_gap_pct = 10;
            default: sender_gap_pct = 35;
         endcase
         if (frame_no == HOLD_FRAME) begin
            hold_request = 1'b1;
         end
         if (frame_no == DRAIN_FRAME) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (pending_readings.size() != 0) @(posedge clock);
         end
         if (sent >= CALM_FROM) begin
            calm = 1'b1;
         end

         tw = pick_word();
         hw = pick_word();
         frame_buf[0] = tw[15:8];
         frame_buf[1] = tw[7:0];
         frame_buf[2] = crc8_step(crc8_step(CRC_INIT, tw[15:8]), tw[7:0]);
         frame_buf[3] = hw[15:8];
         frame_buf[4] = hw[7:0];
         frame_buf[5] = crc8_step(crc8_step(CRC_INIT, hw[15:8]), hw[7:0]);
         len = 6;
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            len = 6;
         end else if (kind < 78) begin
            frame_buf[2] ^= 8'($urandom_range(1, 255));
         end else if (kind < 86) begin
            frame_buf[5] ^= 8'($urandom_range(1, 255));
         end else if (kind < 92) begin
            len = 5;
         end else if (kind < 97) begin
            len = $urandom_range(7, 10);
            for (int i = 6; i < len; i++) begin
               frame_buf[i] = 8'($urandom);
            end
         end else begin
            // noise: random bytes, at least five so both raw words are written
            len = $urandom_range(5, 10);
            for (int i = 0; i < len; i++) begin
               frame_buf[i] = 8'($urandom);
            end
         end

         for (int i = 0; i < len; i++) begin
            offer_byte(frame_buf[i], i == len - 1);
            if (decode_byte(frame_buf[i], i == len - 1, got)) begin
               pending_readings.push_back(got);
            end
            sent++;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
